// ----- src/csp_pkg.sv -----
package csp_pkg;

	// Default configuration
	localparam int unsigned PATH_MAX_DEF  = 65536;
	localparam int unsigned FRAC_BITS_DEF = 16;

	// Fixed field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned IDX_W   = 16;
	localparam int unsigned MAG_W   = COORD_W + 1;   // magnitude of a coordinate difference
	localparam int unsigned PROD_W  = 2 * MAG_W;     // unsigned product of two magnitudes
	localparam int unsigned ACC_W   = PROD_W + 1;    // signed sum of two products

	// Input action codes
	typedef enum logic [1:0] {
		ACT_QUERY = 2'd0,
		ACT_POINT = 2'd1,
		ACT_END   = 2'd2
	} csp_action_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PT_MX,
		ST_PT_MY,
		ST_PT_UPD,
		ST_E_DIFF,
		ST_E_M0,
		ST_E_M1,
		ST_E_M2,
		ST_E_M3,
		ST_E_NUM,
		ST_E_DIV,
		ST_E_USAT,
		ST_E_P0,
		ST_E_P1,
		ST_E_P2,
		ST_E_FIN
	} csp_state_t;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
	} in_item_t;

	typedef struct packed {
		logic                      empty_error;
		logic [IDX_W-1:0]          closest_index;
		logic [IDX_W-1:0]          neighbour_index;
		logic signed [COORD_W-1:0] closest_x;
		logic signed [COORD_W-1:0] closest_y;
		logic signed [COORD_W-1:0] neighbour_x;
		logic signed [COORD_W-1:0] neighbour_y;
		logic signed [COORD_W-1:0] ratio_u;
		logic signed [COORD_W-1:0] projected_x;
		logic signed [COORD_W-1:0] projected_y;
	} out_item_t;

	// Operands of the shared multiplier
	typedef struct packed {
		logic             en;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
		logic             neg;
	} mul_op_t;

	// Magnitude of a signed 33-bit difference; fits 33 unsigned bits
	function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
		logic [MAG_W-1:0] r;
		r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
		return r;
	endfunction

	// Saturate a wide signed value to the 32-bit signed range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > ACC_W'(64'sh7FFF_FFFF)) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -ACC_W'(64'sh8000_0000)) begin
			r = 32'sh8000_0000;
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- src/csp_mul.sv -----
module csp_mul (
	input  logic                          clk,
	input  csp_pkg::mul_op_t              op,
	output logic [csp_pkg::PROD_W-1:0]    prod,
	output logic                          prod_neg
);
	import csp_pkg::*;

	logic [PROD_W-1:0] prod_q;
	logic              neg_q;

	// Unsigned magnitude product, sign carried alongside
	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= PROD_W'(op.a) * PROD_W'(op.b);
			neg_q  <= op.neg;
		end
	end

	assign prod     = prod_q;
	assign prod_neg = neg_q;

endmodule

// ----- src/closest_segment_projector.sv -----
// Channel  Direction  Handshake                   Payload
// item     in         item_valid / item_stall     in_item_t  (action, px, py)
// result   out        result_valid / result_stall out_item_t (one per end marker)
//
// A query point is taken in the idle state. A path point passes ST_PT_MX, ST_PT_MY and
// ST_PT_UPD: two squares via the shared multiplier, then a compare. An end marker goes
// to ST_E_FIN on an empty path; zero length skips the bit-serial restoring divider.
// Reset clears the query point, the path count and the sequencer.
// The result sits in an output register; query and point transfers carry on while it
// waits, and a further end marker waits in its last step until the register is free.
module closest_segment_projector #(
	parameter int unsigned PATH_MAX      = csp_pkg::PATH_MAX_DEF,
	parameter int unsigned FRACTION_BITS = csp_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  csp_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output csp_pkg::out_item_t result
);
	import csp_pkg::*;

	localparam int unsigned CNT_W      = $clog2(PATH_MAX + 1);
	localparam int unsigned NUM_W      = PROD_W + FRACTION_BITS + 1;
	localparam int unsigned DCNT_W     = $clog2(NUM_W + 1);
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
	localparam logic [COORD_W-1:0] U_ONE   = COORD_W'(1) << FRACTION_BITS;

	csp_state_t state_q, state_d;

	// Control state
	logic [CNT_W-1:0]          count_q;
	logic                      min_found_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic                      result_valid_q;

	// Path payload
	logic signed [COORD_W-1:0] in_x_q, in_y_q;
	logic signed [COORD_W-1:0] last0_x_q, last0_y_q, last1_x_q, last1_y_q;
	logic [PROD_W-1:0]         last0_d_q, last1_d_q;
	logic signed [COORD_W-1:0] best_x_q, best_y_q, pair_x_q, pair_y_q;
	logic [IDX_W-1:0]          best_idx_q, pair_idx_q;

	// Projection payload
	logic signed [MAG_W-1:0]   dx_q, dy_q, ex_q, ey_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [PROD_W-1:0]         den_q;
	logic [NUM_W-1:0]          div_num_q;
	logic [PROD_W-1:0]         rem_q;
	logic [MAG_W-1:0]          quo_q;
	logic                      quo_ovf_q;
	logic                      num_neg_q;
	logic [DCNT_W-1:0]         div_cnt_q;
	logic signed [COORD_W-1:0] u_q, proj_x_q, proj_y_q;
	logic                      empty_q;
	out_item_t                 result_q;

	// Shared multiplier
	mul_op_t           mul_op;
	logic [PROD_W-1:0] prod;
	logic              prod_neg;

	csp_mul u_mul (
		.clk      (clk),
		.op       (mul_op),
		.prod     (prod),
		.prod_neg (prod_neg)
	);

	logic item_xfer, result_load;
	assign item_xfer = item_valid && !item_stall;

	// Shared datapath values
	logic signed [ACC_W-1:0]   prod_s;
	logic [PROD_W-1:0]         pt_dist;
	logic [CNT_W-1:0]          km1, km2;
	logic signed [ACC_W-1:0]   num_sum;
	logic [PROD_W-1:0]         num_mag;
	logic [ACC_W-1:0]          rem_try, rem_diff;
	logic                      rem_ge;
	logic [PROD_W-1:0]         rnd;
	logic [PROD_W-1:0]         rnd_sh;
	logic signed [ACC_W-1:0]   proj_base;
	logic signed [ACC_W-1:0]   proj_sum;
	logic                      pos_big, neg_big;
	logic signed [COORD_W-1:0] u_sat;

	always_comb begin
		prod_s   = prod_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
		pt_dist  = acc_q[PROD_W-1:0] + prod;
		km1      = count_q - CNT_W'(1);
		km2      = count_q - CNT_W'(2);
		num_sum  = acc_q + prod_s;
		num_mag  = num_sum[ACC_W-1] ? PROD_W'(-num_sum) : PROD_W'(num_sum);
		rem_try  = {rem_q, div_num_q[NUM_W-1]};
		rem_diff = rem_try - {1'b0, den_q};
		rem_ge   = rem_try >= {1'b0, den_q};
		rnd      = prod + RND_HALF;
		rnd_sh   = rnd >> FRACTION_BITS;
		proj_base = (state_q == ST_E_P1) ? ACC_W'(best_x_q) : ACC_W'(best_y_q);
		proj_sum  = prod_neg ? proj_base - $signed({1'b0, rnd_sh})
		                     : proj_base + $signed({1'b0, rnd_sh});
		pos_big  = quo_ovf_q || (quo_q > MAG_W'(33'h0_7FFF_FFFF));
		neg_big  = quo_ovf_q || (quo_q > MAG_W'(33'h0_8000_0000));
		if (num_neg_q) begin
			u_sat = neg_big ? 32'sh8000_0000 : COORD_W'(-quo_q);
		end else begin
			u_sat = pos_big ? 32'sh7FFF_FFFF : COORD_W'(quo_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_xfer) begin
					case (item.action)
						ACT_POINT: begin
							if (count_q < CNT_W'(PATH_MAX)) state_d = ST_PT_MX;
						end
						ACT_END: begin
							state_d = (count_q == '0) ? ST_E_FIN : ST_E_DIFF;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PT_MX:  state_d = ST_PT_MY;
			ST_PT_MY:  state_d = ST_PT_UPD;
			ST_PT_UPD: state_d = ST_IDLE;
			ST_E_DIFF: state_d = ST_E_M0;
			ST_E_M0:   state_d = ST_E_M1;
			ST_E_M1:   state_d = ST_E_M2;
			ST_E_M2:   state_d = ST_E_M3;
			ST_E_M3:   state_d = ST_E_NUM;
			ST_E_NUM:  state_d = (den_q == '0) ? ST_E_P0 : ST_E_DIV;
			ST_E_DIV:  state_d = (div_cnt_q == DCNT_W'(1)) ? ST_E_USAT : ST_E_DIV;
			ST_E_USAT: state_d = ST_E_P0;
			ST_E_P0:   state_d = ST_E_P1;
			ST_E_P1:   state_d = ST_E_P2;
			ST_E_P2:   state_d = ST_E_FIN;
			ST_E_FIN:  state_d = result_load ? ST_IDLE : ST_E_FIN;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: input stall, result load, multiplier operands
	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		result_load = (state_q == ST_E_FIN) && (!result_valid_q || !result_stall);
		mul_op      = '0;
		case (state_q)
			ST_PT_MX: begin
				mul_op.en = 1'b1;
				mul_op.a  = mag33(MAG_W'(in_x_q) - MAG_W'(qx_q));
				mul_op.b  = mul_op.a;
			end
			ST_PT_MY: begin
				mul_op.en = 1'b1;
				mul_op.a  = mag33(MAG_W'(in_y_q) - MAG_W'(qy_q));
				mul_op.b  = mul_op.a;
			end
			ST_E_M0: begin
				mul_op.en = 1'b1;
				mul_op.a  = mag33(dx_q);
				mul_op.b  = mul_op.a;
			end
			ST_E_M1: begin
				mul_op.en = 1'b1;
				mul_op.a  = mag33(dy_q);
				mul_op.b  = mul_op.a;
			end
			ST_E_M2: begin
				mul_op.en  = 1'b1;
				mul_op.a   = mag33(ex_q);
				mul_op.b   = mag33(dx_q);
				mul_op.neg = ex_q[MAG_W-1] ^ dx_q[MAG_W-1];
			end
			ST_E_M3: begin
				mul_op.en  = 1'b1;
				mul_op.a   = mag33(ey_q);
				mul_op.b   = mag33(dy_q);
				mul_op.neg = ey_q[MAG_W-1] ^ dy_q[MAG_W-1];
			end
			ST_E_P0: begin
				mul_op.en  = 1'b1;
				mul_op.a   = mag33(MAG_W'(u_q));
				mul_op.b   = mag33(dx_q);
				mul_op.neg = u_q[COORD_W-1] ^ dx_q[MAG_W-1];
			end
			ST_E_P1: begin
				mul_op.en  = 1'b1;
				mul_op.a   = mag33(MAG_W'(u_q));
				mul_op.b   = mag33(dy_q);
				mul_op.neg = u_q[COORD_W-1] ^ dy_q[MAG_W-1];
			end
			default: mul_op = '0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			min_found_q    <= 1'b0;
			qx_q           <= '0;
			qy_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_xfer && item.action == ACT_QUERY) begin
				qx_q <= item.px;
				qy_q <= item.py;
			end
			if (state_q == ST_PT_UPD) begin
				count_q <= count_q + CNT_W'(1);
				if (!min_found_q && count_q != '0 && pt_dist > last0_d_q) min_found_q <= 1'b1;
			end
			if (result_load) begin
				count_q     <= '0;
				min_found_q <= 1'b0;
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Point tracking
	always_ff @(posedge clk) begin
		if (item_xfer && item.action == ACT_POINT) begin
			in_x_q <= item.px;
			in_y_q <= item.py;
		end
		if (state_q == ST_PT_MY) acc_q <= $signed({1'b0, prod});
		if (state_q == ST_PT_UPD) begin
			// first rise in distance fixes the closest point
			if (!min_found_q && count_q != '0 && pt_dist > last0_d_q) begin
				best_x_q   <= last0_x_q;
				best_y_q   <= last0_y_q;
				best_idx_q <= IDX_W'(km1);
				if (count_q >= CNT_W'(2) && last1_d_q < pt_dist) begin
					pair_x_q   <= last1_x_q;
					pair_y_q   <= last1_y_q;
					pair_idx_q <= IDX_W'(km2);
				end else begin
					pair_x_q   <= in_x_q;
					pair_y_q   <= in_y_q;
					pair_idx_q <= IDX_W'(count_q);
				end
			end
			last1_x_q <= last0_x_q;
			last1_y_q <= last0_y_q;
			last1_d_q <= last0_d_q;
			last0_x_q <= in_x_q;
			last0_y_q <= in_y_q;
			last0_d_q <= pt_dist;
		end
		// end marker with no rise seen: last point is closest
		if (item_xfer && item.action == ACT_END) begin
			empty_q <= (count_q == '0);
			if (!min_found_q) begin
				best_x_q   <= last0_x_q;
				best_y_q   <= last0_y_q;
				best_idx_q <= IDX_W'(km1);
				if (count_q >= CNT_W'(2)) begin
					pair_x_q   <= last1_x_q;
					pair_y_q   <= last1_y_q;
					pair_idx_q <= IDX_W'(km2);
				end else begin
					pair_x_q   <= last0_x_q;
					pair_y_q   <= last0_y_q;
					pair_idx_q <= IDX_W'(km1);
				end
			end
		end

		// Segment and query offsets
		if (state_q == ST_E_DIFF) begin
			dx_q <= MAG_W'(pair_x_q) - MAG_W'(best_x_q);
			dy_q <= MAG_W'(pair_y_q) - MAG_W'(best_y_q);
			ex_q <= MAG_W'(qx_q) - MAG_W'(best_x_q);
			ey_q <= MAG_W'(qy_q) - MAG_W'(best_y_q);
		end
		// Squared length, then dot product
		if (state_q == ST_E_M1) acc_q <= $signed({1'b0, prod});
		if (state_q == ST_E_M2) den_q <= acc_q[PROD_W-1:0] + prod;
		if (state_q == ST_E_M3) acc_q <= prod_s;

		// Divider set-up: rounded numerator, cleared remainder
		if (state_q == ST_E_NUM) begin
			num_neg_q <= num_sum[ACC_W-1];
			div_num_q <= {1'b0, num_mag, {FRACTION_BITS{1'b0}}} + NUM_W'(den_q >> 1);
			rem_q     <= '0;
			quo_q     <= '0;
			quo_ovf_q <= 1'b0;
			div_cnt_q <= DCNT_W'(NUM_W);
			if (den_q == '0) u_q <= U_ONE;
		end
		// Restoring division, one quotient bit a cycle
		if (state_q == ST_E_DIV) begin
			rem_q     <= rem_ge ? rem_diff[PROD_W-1:0] : rem_try[PROD_W-1:0];
			div_num_q <= div_num_q << 1;
			quo_q     <= {quo_q[MAG_W-2:0], rem_ge};
			quo_ovf_q <= quo_ovf_q | quo_q[MAG_W-1];
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
		if (state_q == ST_E_USAT) u_q <= u_sat;

		// Projection, rounded and saturated per axis
		if (state_q == ST_E_P1) proj_x_q <= sat32(proj_sum);
		if (state_q == ST_E_P2) proj_y_q <= sat32(proj_sum);

		// Result register
		if (result_load) begin
			if (empty_q) begin
				result_q <= '{empty_error: 1'b1, default: '0};
			end else begin
				result_q.empty_error     <= 1'b0;
				result_q.closest_index   <= best_idx_q;
				result_q.neighbour_index <= pair_idx_q;
				result_q.closest_x       <= best_x_q;
				result_q.closest_y       <= best_y_q;
				result_q.neighbour_x     <= pair_x_q;
				result_q.neighbour_y     <= pair_y_q;
				result_q.ratio_u         <= u_q;
				result_q.projected_x     <= proj_x_q;
				result_q.projected_y     <= proj_y_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PATH_MAX))
		else $error("point count beyond path limit");

	a_min_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		min_found_q |-> count_q >= CNT_W'(2))
		else $error("minimum flagged with fewer than two points");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_E_DIV |-> div_cnt_q != '0)
		else $error("divider running with exhausted count");

	a_clear_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> count_q == '0 && !min_found_q && result_valid_q)
		else $error("path not cleared after result load");

endmodule

// ----- dv/closest_segment_projector_tb.sv -----
module closest_segment_projector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csp_pkg::*;

	typedef logic [127:0] u128_t;

	localparam int unsigned PATH_LIMIT   = PATH_MAX_DEF;
	localparam int unsigned FRAC         = FRAC_BITS_DEF;
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [31:0] C_MAX        = 32'h7fff_ffff;
	localparam logic [31:0] C_MIN        = 32'h8000_0000;
	localparam logic [31:0] C_ONE        = 32'h0001_0000;
	localparam int          QUIET_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 200;

	// Tracks the path and predicts one projection per end marker
	class projection_scoreboard;
		longint      query_x, query_y;
		int unsigned n_points;
		bit          min_seen;
		longint      recent_x[2], recent_y[2];
		u128_t       recent_d[2];
		longint      best_x, best_y, pair_x, pair_y;
		int unsigned best_idx, pair_idx;
		out_item_t   expected_q[$];
		int unsigned errors;

		function new();
			query_x = 0;
			query_y = 0;
			errors  = 0;
			clear_path();
		endfunction

		function void clear_path();
			n_points = 0;
			min_seen = 1'b0;
			for (int i = 0; i < 2; i++) begin
				recent_x[i] = 0;
				recent_y[i] = 0;
				recent_d[i] = '0;
			end
			best_x   = 0;
			best_y   = 0;
			pair_x   = 0;
			pair_y   = 0;
			best_idx = 0;
			pair_idx = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function u128_t sq_dist(longint x, longint y);
			u128_t ax, ay;
			ax = (x - query_x < 0) ? query_x - x : x - query_x;
			ay = (y - query_y < 0) ? query_y - y : y - query_y;
			return ax * ax + ay * ay;
		endfunction

		// First strict rise in distance fixes the closest point and its neighbour
		function void take_point(longint x, longint y);
			u128_t d;
			if (n_points >= PATH_LIMIT) return;
			d = sq_dist(x, y);
			if (!min_seen && n_points >= 1 && d > recent_d[0]) begin
				min_seen = 1'b1;
				best_x   = recent_x[0];
				best_y   = recent_y[0];
				best_idx = n_points - 1;
				if (n_points >= 2 && recent_d[1] < d) begin
					pair_x   = recent_x[1];
					pair_y   = recent_y[1];
					pair_idx = n_points - 2;
				end else begin
					pair_x   = x;
					pair_y   = y;
					pair_idx = n_points;
				end
			end
			recent_x[1] = recent_x[0];
			recent_y[1] = recent_y[0];
			recent_d[1] = recent_d[0];
			recent_x[0] = x;
			recent_y[0] = y;
			recent_d[0] = d;
			n_points++;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// base + u * delta, product rounded half away from zero
		function longint project_axis(longint base, longint delta, longint u);
			longint unsigned m, r;
			bit              neg;
			m   = (u < 0 ? -u : u) * (delta < 0 ? -delta : delta);
			r   = (m + (64'd1 << (FRAC - 1))) >> FRAC;
			neg = (u < 0) != (delta < 0);
			return sat32(neg ? base - longint'(r) : base + longint'(r));
		endfunction

		function out_item_t finish_path();
			out_item_t               o;
			longint                  x1, y1, x2, y2, dx, dy, u, px, py;
			u128_t                   den, nmag, q, adx, ady;
			logic signed [127:0]     sa, sb, sdx, sdy, num;
			o = '0;
			if (n_points == 0) begin
				o.empty_error = 1'b1;
				return o;
			end
			if (!min_seen) begin
				best_x   = recent_x[0];
				best_y   = recent_y[0];
				best_idx = n_points - 1;
				if (n_points >= 2) begin
					pair_x   = recent_x[1];
					pair_y   = recent_y[1];
					pair_idx = n_points - 2;
				end else begin
					pair_x   = best_x;
					pair_y   = best_y;
					pair_idx = best_idx;
				end
			end
			x1  = best_x;
			y1  = best_y;
			x2  = pair_x;
			y2  = pair_y;
			dx  = x2 - x1;
			dy  = y2 - y1;
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			den = adx * adx + ady * ady;
			// zero-length segment takes the neighbour
			if (den == 0) begin
				u = longint'(1) << FRAC;
			end else begin
				sa   = query_x - x1;
				sb   = query_y - y1;
				sdx  = dx;
				sdy  = dy;
				num  = sa * sdx + sb * sdy;
				nmag = (num < 0) ? -num : num;
				q    = ((nmag << FRAC) + (den >> 1)) / den;
				if (num < 0) begin
					u = (q > 128'd2147483648) ? -64'sd2147483648 : -longint'(q[63:0]);
				end else begin
					u = (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q[63:0]);
				end
			end
			px = project_axis(x1, dx, u);
			py = project_axis(y1, dy, u);
			o.closest_index   = best_idx[15:0];
			o.neighbour_index = pair_idx[15:0];
			o.closest_x       = x1[31:0];
			o.closest_y       = y1[31:0];
			o.neighbour_x     = x2[31:0];
			o.neighbour_y     = y2[31:0];
			o.ratio_u         = u[31:0];
			o.projected_x     = px[31:0];
			o.projected_y     = py[31:0];
			return o;
		endfunction

		// Accepted input transfer
		function void note_item(in_item_t it);
			case (it.action)
				ACT_QUERY: begin
					query_x = longint'($signed(it.px));
					query_y = longint'($signed(it.py));
				end
				ACT_POINT: begin
					take_point(longint'($signed(it.px)), longint'($signed(it.py)));
				end
				ACT_END: begin
					expected_q.push_back(finish_path());
					clear_path();
				end
				default: begin
				end
			endcase
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		endtask

		// Accepted result transfer against the oldest prediction
		task check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report("unexpected result", 64'd1, 64'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.empty_error !== want.empty_error)
				report("empty_error", got.empty_error, want.empty_error);
			if (got.closest_index !== want.closest_index)
				report("closest_index", got.closest_index, want.closest_index);
			if (got.neighbour_index !== want.neighbour_index)
				report("neighbour_index", got.neighbour_index, want.neighbour_index);
			if (got.closest_x !== want.closest_x)
				report("closest_x", got.closest_x, want.closest_x);
			if (got.closest_y !== want.closest_y)
				report("closest_y", got.closest_y, want.closest_y);
			if (got.neighbour_x !== want.neighbour_x)
				report("neighbour_x", got.neighbour_x, want.neighbour_x);
			if (got.neighbour_y !== want.neighbour_y)
				report("neighbour_y", got.neighbour_y, want.neighbour_y);
			if (got.ratio_u !== want.ratio_u)
				report("ratio_u", got.ratio_u, want.ratio_u);
			if (got.projected_x !== want.projected_x)
				report("projected_x", got.projected_x, want.projected_x);
			if (got.projected_y !== want.projected_y)
				report("projected_y", got.projected_y, want.projected_y);
		endtask
	endclass

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	in_item_t    item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;

	int unsigned send_idle_pct = 10;
	int unsigned recv_idle_pct = 83;
	int          quiet_cycles  = 0;

	projection_scoreboard sb = new();

	closest_segment_projector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(item);
			if (result_valid && !result_stall) sb.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// One input transfer; valid stays high for a back-to-back follow-up
	task automatic send_item(logic [1:0] act, logic [31:0] x, logic [31:0] y);
		in_item_t it;
		it.action = act;
		it.px     = x;
		it.py     = y;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(7))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	// Random paths: scattered, clustered round the query, or along a line through it
	task automatic random_paths(int unsigned n_items);
		int unsigned sent, len, shape, i;
		logic [31:0] qx, qy, x, y, sx, sy, stx, sty;
		sent = 0;
		qx   = 0;
		qy   = 0;
		while (sent < n_items) begin
			if (sent == 0 || $urandom_range(3) == 0) begin
				qx = pick_coord();
				qy = pick_coord();
				send_item(ACT_QUERY, qx, qy);
				sent++;
			end
			len   = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 7);
			shape = $urandom_range(3);
			stx   = $urandom() >> $urandom_range(4, 31);
			sty   = $urandom() >> $urandom_range(4, 31);
			if ($urandom_range(1)) stx = -stx;
			if ($urandom_range(1)) sty = -sty;
			sx = qx - stx * (len / 2);
			sy = qy - sty * (len / 2);
			for (i = 0; i < len; i++) begin
				case (shape)
					0: begin
						x = pick_coord();
						y = pick_coord();
					end
					1: begin
						x = qx + $urandom_range(8) - 4;
						y = qy + $urandom_range(8) - 4;
					end
					default: begin
						x = sx + stx * i + $urandom_range(2) - 1;
						y = sy + sty * i + $urandom_range(2) - 1;
					end
				endcase
				// query moved mid-path
				if ($urandom_range(19) == 0) begin
					qx = pick_coord();
					qy = pick_coord();
					send_item(ACT_QUERY, qx, qy);
					sent++;
				end
				if ($urandom_range(29) == 0) send_item(ACT_UNUSED, $urandom(), $urandom());
				send_item(ACT_POINT, x, y);
				sent++;
			end
			send_item(ACT_END, $urandom(), $urandom());
			sent++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty path straight after reset
		send_item(ACT_END, '0, '0);
		// single point at the far corner from the query
		send_item(ACT_QUERY, C_MAX, C_MIN);
		send_item(ACT_POINT, C_MIN, C_MAX);
		send_item(ACT_END, C_MAX, C_MAX);
		// zero-length segment: a repeated point
		send_item(ACT_QUERY, C_ONE, 32'h0002_0000);
		send_item(ACT_POINT, 32'h0005_0000, 32'hfffd_0000);
		send_item(ACT_POINT, 32'h0005_0000, 32'hfffd_0000);
		send_item(ACT_END, '0, '0);
		// minimum in the middle, equal neighbours, a point after the minimum
		send_item(ACT_QUERY, '0, '0);
		send_item(ACT_POINT, 32'h0003_0000, '0);
		send_item(ACT_POINT, C_ONE, '0);
		send_item(ACT_POINT, '0, 32'h0003_0000);
		send_item(ACT_POINT, 32'h0005_0000, '0);
		send_item(ACT_END, '0, '0);
		// minimum at the first point, query moved during the path, unused action
		send_item(ACT_POINT, C_ONE, C_ONE);
		send_item(ACT_POINT, 32'h0004_0000, '0);
		send_item(ACT_QUERY, C_MAX, C_MAX);
		send_item(ACT_UNUSED, C_MIN, C_MIN);
		send_item(ACT_POINT, 32'h0005_0000, '0);
		send_item(ACT_END, '0, '0);
		// diagonal unit segments: ratio saturates low, projection saturates high and low
		send_item(ACT_POINT, C_MAX - 1, '0);
		send_item(ACT_POINT, C_MAX, 32'd1);
		send_item(ACT_END, '0, '0);
		send_item(ACT_QUERY, C_MIN, C_MIN);
		send_item(ACT_POINT, C_MIN + 1, '0);
		send_item(ACT_POINT, C_MIN, 32'hffff_ffff);
		send_item(ACT_END, '0, '0);

		random_paths(110);
		send_idle_pct = 83;
		recv_idle_pct = 10;
		random_paths(115);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_paths(115);
		item_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
